// ===== design/sdlp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Switch debounce package
// Shared types and constants for the debouncer with long-press detection.
// ----------------------------------------------------------------------------
package sdlp_pkg;

	// Width of the internal time arithmetic; all differences wrap at this width.
	localparam int TimeWidth = 32;
	localparam int NowWidth = 32;
	localparam int PeriodWidth = 16;
	localparam int CfgIndexWidth = 1;

	localparam logic [PeriodWidth-1:0] DebounceReset = PeriodWidth'(50);
	localparam logic [PeriodWidth-1:0] LongPressReset = PeriodWidth'(1000);

	typedef logic [TimeWidth-1:0] time_t;
	typedef logic [PeriodWidth-1:0] period_t;

	typedef enum logic [CfgIndexWidth-1:0] {
		REG_DEBOUNCE_PERIOD = 1'b0,
		REG_LONG_PRESS_PERIOD = 1'b1
	} cfg_index_t;

	typedef struct packed {
		period_t debounce_period_ms;
		period_t long_press_period_ms;
	} cfg_t;

	typedef struct packed {
		logic switched;
		logic is_on;
		logic pushed;
		logic released;
		logic long_press;
	} result_t;

endpackage

`default_nettype wire

// ===== design/sdlp_poll_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Poll channel
// Valid/ready channel carrying one switch poll.
// ----------------------------------------------------------------------------
interface sdlp_poll_if;
	logic valid;
	logic ready;
	logic raw_level;
	logic [sdlp_pkg::NowWidth-1:0] now_ms;
	logic clear_events;

	modport source (output valid, raw_level, now_ms, clear_events, input ready);
	modport sink (input valid, raw_level, now_ms, clear_events, output ready);
endinterface

`default_nettype wire

// ===== design/sdlp_result_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying the debounced switch status.
// ----------------------------------------------------------------------------
interface sdlp_result_if;
	logic valid;
	logic ready;
	logic switched;
	logic is_on;
	logic pushed;
	logic released;
	logic long_press;

	modport source (output valid, switched, is_on, pushed, released, long_press,
		input ready);
	modport sink (input valid, switched, is_on, pushed, released, long_press,
		output ready);
endinterface

`default_nettype wire

// ===== design/sdlp_cfg_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Configuration write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface sdlp_cfg_if;
	logic valid;
	logic ready;
	logic [sdlp_pkg::CfgIndexWidth-1:0] index;
	logic [sdlp_pkg::PeriodWidth-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== design/sdlp_cfg_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Configuration registers
// Holds the debounce and long-press periods.
// ----------------------------------------------------------------------------
module sdlp_cfg_regs (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic wr_en,
	input  wire logic [sdlp_pkg::CfgIndexWidth-1:0] wr_index,
	input  wire logic [sdlp_pkg::PeriodWidth-1:0] wr_data,
	output sdlp_pkg::cfg_t cfg
);
	sdlp_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_period_ms <= sdlp_pkg::DebounceReset;
			cfg_q.long_press_period_ms <= sdlp_pkg::LongPressReset;
		end else if (wr_en) begin
			case (sdlp_pkg::cfg_index_t'(wr_index))
				sdlp_pkg::REG_DEBOUNCE_PERIOD: cfg_q.debounce_period_ms <= wr_data;
				sdlp_pkg::REG_LONG_PRESS_PERIOD: cfg_q.long_press_period_ms <= wr_data;
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	assign cfg = cfg_q;
endmodule

`default_nettype wire

// ===== design/sdlp_update.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Debounce state update
// Holds the debounce and press state and computes the status after a poll.
// ----------------------------------------------------------------------------
module sdlp_update (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic advance,
	input  wire logic raw_level,
	input  wire logic [sdlp_pkg::NowWidth-1:0] now_ms,
	input  wire logic clear_events,
	input  wire sdlp_pkg::cfg_t cfg,
	output sdlp_pkg::result_t result
);
	logic previous_raw_q;
	logic stable_level_q;
	sdlp_pkg::time_t change_time_q;
	sdlp_pkg::time_t press_time_q;
	logic hold_active_q;
	logic switched_flag_q;
	logic hold_flag_q;

	sdlp_pkg::time_t now_t;
	sdlp_pkg::time_t change_time_d;
	sdlp_pkg::time_t press_time_d;
	sdlp_pkg::time_t since_change;
	sdlp_pkg::time_t since_press;
	logic settled;
	logic held_long;
	logic stable_level_d;
	logic hold_active_d;
	logic switched_flag_d;
	logic hold_flag_d;

	assign now_t = sdlp_pkg::time_t'(now_ms);
	// A raw edge restarts the debounce window at this poll.
	assign change_time_d = (raw_level != previous_raw_q) ? now_t : change_time_q;
	assign since_change = now_t - change_time_d;
	assign since_press = now_t - press_time_q;
	assign settled = since_change > sdlp_pkg::time_t'(cfg.debounce_period_ms);
	assign held_long = since_press > sdlp_pkg::time_t'(cfg.long_press_period_ms);

	always_comb begin
		stable_level_d = stable_level_q;
		press_time_d = press_time_q;
		hold_active_d = hold_active_q;
		// Clear first so an event in this same poll still sets the flag.
		switched_flag_d = switched_flag_q & ~clear_events;
		hold_flag_d = hold_flag_q & ~clear_events;
		if (settled) begin
			if (raw_level != stable_level_q) begin
				stable_level_d = raw_level;
				if (raw_level) begin
					hold_active_d = 1'b0;
				end else begin
					press_time_d = now_t;
				end
				switched_flag_d = 1'b1;
			end else if (!stable_level_q && !hold_active_q && held_long) begin
				hold_active_d = 1'b1;
				hold_flag_d = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			previous_raw_q <= 1'b1;
			stable_level_q <= 1'b1;
			change_time_q <= '0;
			press_time_q <= '0;
			hold_active_q <= 1'b0;
			switched_flag_q <= 1'b0;
			hold_flag_q <= 1'b0;
		end else if (advance) begin
			previous_raw_q <= raw_level;
			stable_level_q <= stable_level_d;
			change_time_q <= change_time_d;
			press_time_q <= press_time_d;
			hold_active_q <= hold_active_d;
			switched_flag_q <= switched_flag_d;
			hold_flag_q <= hold_flag_d;
		end
	end

	always_comb begin
		result.switched = switched_flag_d;
		result.is_on = ~stable_level_d;
		result.pushed = switched_flag_d & ~stable_level_d;
		result.released = switched_flag_d & stable_level_d;
		result.long_press = hold_flag_d;
	end
endmodule

`default_nettype wire

// ===== design/sdlp_out_reg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Result register
// Holds one status transaction until the sink takes it.
// ----------------------------------------------------------------------------
module sdlp_out_reg (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic load,
	input  wire sdlp_pkg::result_t load_data,
	input  wire logic out_ready,
	output logic out_valid,
	output sdlp_pkg::result_t out_data,
	output logic can_load
);
	logic valid_q;
	sdlp_pkg::result_t data_q;

	assign can_load = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (can_load) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= load_data;
		end
	end

	assign out_valid = valid_q;
	assign out_data = data_q;
endmodule

`default_nettype wire

// ===== design/switch_debounce_long_press_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Switch debouncer with long-press detection
// A poll's status is registered in the result register and shows in the cycle after the poll is accepted.
// Throughput: one poll per cycle while the poll channel is not stalled.
// The poll channel stalls only while the result register holds an untaken status.
// Configuration ready is always high, so every write is accepted when offered.
// Reset: asynchronous, active low; restores released level, clears flags,
// and loads the default periods (50 ms debounce, 1000 ms long press).
// ----------------------------------------------------------------------------
module switch_debounce_long_press_core (
	input  wire logic clk,
	input  wire logic arst_n,
	sdlp_poll_if.sink poll,
	sdlp_result_if.source result,
	sdlp_cfg_if.sink cfg
);
	sdlp_pkg::cfg_t cfg_val;
	sdlp_pkg::result_t next_result;
	sdlp_pkg::result_t held_result;
	logic can_load;
	logic poll_fire;

	assign cfg.ready = 1'b1;
	assign poll.ready = can_load;
	assign poll_fire = poll.valid && can_load;

	sdlp_cfg_regs u_cfg_regs (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(cfg.valid),
		.wr_index(cfg.index),
		.wr_data(cfg.data),
		.cfg(cfg_val)
	);

	sdlp_update u_update (
		.clk(clk),
		.arst_n(arst_n),
		.advance(poll_fire),
		.raw_level(poll.raw_level),
		.now_ms(poll.now_ms),
		.clear_events(poll.clear_events),
		.cfg(cfg_val),
		.result(next_result)
	);

	sdlp_out_reg u_out_reg (
		.clk(clk),
		.arst_n(arst_n),
		.load(poll_fire),
		.load_data(next_result),
		.out_ready(result.ready),
		.out_valid(result.valid),
		.out_data(held_result),
		.can_load(can_load)
	);

	assign result.switched = held_result.switched;
	assign result.is_on = held_result.is_on;
	assign result.pushed = held_result.pushed;
	assign result.released = held_result.released;
	assign result.long_press = held_result.long_press;
endmodule

`default_nettype wire

// ===== design/sdlp_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Port checker
// Watches the core's ports for handshake and status consistency.
// ----------------------------------------------------------------------------
module sdlp_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic poll_valid,
	input wire logic poll_ready,
	input wire logic res_valid,
	input wire logic res_ready,
	input wire logic switched,
	input wire logic is_on,
	input wire logic pushed,
	input wire logic released
);
	// Hold a stalled status transaction unchanged.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid
			&& $stable({switched, is_on, pushed, released}))
		else $error("result changed while stalled");

	// Every accepted poll shows up as a status on the next cycle.
	a_poll_to_res: assert property (@(posedge clk) disable iff (!arst_n)
		poll_valid && poll_ready |=> res_valid)
		else $error("accepted poll produced no result");

	a_pushed: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> pushed == (switched && is_on))
		else $error("pushed inconsistent with switched and is_on");

	a_released: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> released == (switched && !is_on))
		else $error("released inconsistent with switched and is_on");
endmodule

bind switch_debounce_long_press_core sdlp_checker u_sdlp_checker (
	.clk(clk),
	.arst_n(arst_n),
	.poll_valid(poll.valid),
	.poll_ready(poll.ready),
	.res_valid(result.valid),
	.res_ready(result.ready),
	.switched(result.switched),
	.is_on(result.is_on),
	.pushed(result.pushed),
	.released(result.released)
);

`default_nettype wire

// ===== tb/tb_switch_debounce_long_press_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Switch debouncer testbench
// Drives timed switch polls and configuration writes into the debouncer core,
// predicts each status transaction in a behavioral model of the debounce and
// long-press logic (or takes it from the script), compares the status stream
// field by field under random idling and backpressure on both channels.
// ----------------------------------------------------------------------------
module tb_switch_debounce_long_press_core;

	localparam int CycleLimit = 200000;
	localparam int PhaseItems = 150;

	localparam sdlp_pkg::cfg_index_t RegDeb = sdlp_pkg::REG_DEBOUNCE_PERIOD;
	localparam sdlp_pkg::cfg_index_t RegLong = sdlp_pkg::REG_LONG_PRESS_PERIOD;

	typedef enum logic {ROW_POLL, ROW_WRITE} row_kind_t;

	typedef struct packed {
		row_kind_t kind;
		logic raw;
		sdlp_pkg::time_t now;
		logic clr;
		logic typed;
		sdlp_pkg::result_t status;
		sdlp_pkg::cfg_index_t idx;
		sdlp_pkg::period_t data;
	} script_row_t;

	localparam sdlp_pkg::result_t ST_IDLE = '0;
	localparam sdlp_pkg::result_t ST_PUSH = '{switched: 1'b1, is_on: 1'b1,
		pushed: 1'b1, released: 1'b0, long_press: 1'b0};
	localparam sdlp_pkg::result_t ST_HELD = '{switched: 1'b0, is_on: 1'b1,
		pushed: 1'b0, released: 1'b0, long_press: 1'b1};
	localparam sdlp_pkg::result_t ST_RELEASE = '{switched: 1'b1, is_on: 1'b0,
		pushed: 1'b0, released: 1'b1, long_press: 1'b0};

	// Default periods first (50 ms debounce, 1000 ms long press), then zero and
	// maximum periods.
	localparam int ScriptLen = 30;
	localparam script_row_t Script [ScriptLen] = '{
		'{ROW_POLL, 1'b1, 32'h0000_0000, 1'b0, 1'b1, ST_IDLE, RegDeb, 16'd0},
		'{ROW_POLL, 1'b0, 32'd10, 1'b0, 1'b0, ST_IDLE, RegDeb, 16'd0},
		'{ROW_POLL, 1'b0, 32'd60, 1'b0, 1'b1, ST_IDLE, RegDeb, 16'd0},
		'{ROW_POLL, 1'b0, 32'd61, 1'b0, 1'b1, ST_PUSH, RegDeb, 16'd0},
		'{ROW_POLL, 1'b0, 32'd1061, 1'b0, 1'b0, ST_IDLE, RegDeb, 16'd0},
		'{ROW_POLL, 1'b0, 32'd1062, 1'b1, 1'b1, ST_HELD, RegDeb, 16'd0},
		'{ROW_POLL, 1'b0, 32'd5000, 1'b1, 1'b0, ST_IDLE, RegDeb, 16'd0},
		'{ROW_POLL, 1'b1, 32'd5001, 1'b0, 1'b0, ST_IDLE, RegDeb, 16'd0},
		'{ROW_POLL, 1'b0, 32'd5002, 1'b0, 1'b0, ST_IDLE, RegDeb, 16'd0},
		'{ROW_POLL, 1'b1, 32'd5003, 1'b0, 1'b0, ST_IDLE, RegDeb, 16'd0},
		'{ROW_POLL, 1'b1, 32'd5054, 1'b0, 1'b1, ST_RELEASE, RegDeb, 16'd0},
		'{ROW_POLL, 1'b1, 32'hFFFF_FFFF, 1'b1, 1'b0, ST_IDLE, RegDeb, 16'd0},
		'{ROW_POLL, 1'b0, 32'hFFFF_FFF0, 1'b0, 1'b0, ST_IDLE, RegDeb, 16'd0},
		'{ROW_POLL, 1'b0, 32'h0000_0020, 1'b0, 1'b0, ST_IDLE, RegDeb, 16'd0},
		'{ROW_POLL, 1'b0, 32'h0000_0023, 1'b0, 1'b0, ST_IDLE, RegDeb, 16'd0},
		'{ROW_POLL, 1'b0, 32'h0000_0010, 1'b0, 1'b0, ST_IDLE, RegDeb, 16'd0},
		'{ROW_WRITE, 1'b0, 32'h0, 1'b0, 1'b0, ST_IDLE, RegDeb, 16'd0},
		'{ROW_WRITE, 1'b0, 32'h0, 1'b0, 1'b0, ST_IDLE, RegLong, 16'd0},
		'{ROW_POLL, 1'b1, 32'h0000_0010, 1'b1, 1'b0, ST_IDLE, RegDeb, 16'd0},
		'{ROW_POLL, 1'b1, 32'h0000_0011, 1'b0, 1'b0, ST_IDLE, RegDeb, 16'd0},
		'{ROW_POLL, 1'b0, 32'h0000_0011, 1'b0, 1'b0, ST_IDLE, RegDeb, 16'd0},
		'{ROW_POLL, 1'b0, 32'h0000_0012, 1'b0, 1'b0, ST_IDLE, RegDeb, 16'd0},
		'{ROW_POLL, 1'b0, 32'h0000_0013, 1'b0, 1'b0, ST_IDLE, RegDeb, 16'd0},
		'{ROW_WRITE, 1'b0, 32'h0, 1'b0, 1'b0, ST_IDLE, RegDeb, 16'hFFFF},
		'{ROW_WRITE, 1'b0, 32'h0, 1'b0, 1'b0, ST_IDLE, RegLong, 16'hFFFF},
		'{ROW_POLL, 1'b1, 32'h0000_0013, 1'b1, 1'b0, ST_IDLE, RegDeb, 16'd0},
		'{ROW_POLL, 1'b1, 32'h0001_0013, 1'b0, 1'b0, ST_IDLE, RegDeb, 16'd0},
		'{ROW_POLL, 1'b0, 32'h0001_0013, 1'b0, 1'b0, ST_IDLE, RegDeb, 16'd0},
		'{ROW_POLL, 1'b0, 32'h0002_0014, 1'b0, 1'b0, ST_IDLE, RegDeb, 16'd0},
		'{ROW_POLL, 1'b0, 32'h0003_0014, 1'b0, 1'b0, ST_IDLE, RegDeb, 16'd0}
	};

	logic clk;
	logic arst_n;

	sdlp_poll_if poll_ch ();
	sdlp_result_if status_ch ();
	sdlp_cfg_if cfg_ch ();

	switch_debounce_long_press_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.poll(poll_ch),
		.result(status_ch),
		.cfg(cfg_ch)
	);

	// Predicted switch state and its configuration
	logic last_raw;
	logic deb_level;
	sdlp_pkg::time_t change_at;
	sdlp_pkg::time_t press_at;
	logic hold_seen;
	logic switched_sticky;
	logic long_sticky;
	sdlp_pkg::period_t debounce_ms;
	sdlp_pkg::period_t long_press_ms;

	sdlp_pkg::result_t status_q [$];
	int src_idle_pct;
	int sink_idle_pct;
	int hold_left;
	int fail_cnt;
	int cycle_cnt;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic sdlp_pkg::result_t poll_switch(logic raw, sdlp_pkg::time_t now,
		logic clr);
		sdlp_pkg::result_t st;
		if (clr) begin
			switched_sticky = 1'b0;
			long_sticky = 1'b0;
		end
		if (raw != last_raw)
			change_at = now;
		if (sdlp_pkg::time_t'(now - change_at) > sdlp_pkg::time_t'(debounce_ms)) begin
			if (raw != deb_level) begin
				deb_level = raw;
				if (raw)
					hold_seen = 1'b0;
				else
					press_at = now;
				switched_sticky = 1'b1;
			end else if (!deb_level && !hold_seen &&
					sdlp_pkg::time_t'(now - press_at) >
					sdlp_pkg::time_t'(long_press_ms)) begin
				hold_seen = 1'b1;
				long_sticky = 1'b1;
			end
		end
		last_raw = raw;
		st.switched = switched_sticky;
		st.is_on = !deb_level;
		st.pushed = switched_sticky & !deb_level;
		st.released = switched_sticky & deb_level;
		st.long_press = long_sticky;
		return st;
	endfunction

	// Offer one poll, leave valid high after the transaction.
	task automatic send_poll(logic raw, sdlp_pkg::time_t now, logic clr,
		logic typed = 1'b0, sdlp_pkg::result_t typed_status = '0);
		sdlp_pkg::result_t st;
		if ($urandom_range(99) < src_idle_pct) begin
			poll_ch.valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < src_idle_pct);
		end
		poll_ch.valid <= 1'b1;
		poll_ch.raw_level <= raw;
		poll_ch.now_ms <= now;
		poll_ch.clear_events <= clr;
		do
			@(posedge clk);
		while (!poll_ch.ready);
		st = poll_switch(raw, now, clr);
		status_q.push_back(typed ? typed_status : st);
	endtask

	task automatic write_reg(sdlp_pkg::cfg_index_t idx, sdlp_pkg::period_t val);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= val;
		do
			@(posedge clk);
		while (!cfg_ch.ready);
		case (idx)
			sdlp_pkg::REG_DEBOUNCE_PERIOD: debounce_ms = val;
			sdlp_pkg::REG_LONG_PRESS_PERIOD: long_press_ms = val;
			default: ;
		endcase
	endtask

	// Hold the poll channel until every predicted status has been taken.
	task automatic wait_drained();
		poll_ch.valid <= 1'b0;
		while (status_q.size() != 0)
			@(negedge clk);
		@(posedge clk);
	endtask

	task automatic run_phase(sdlp_pkg::period_t deb, sdlp_pkg::period_t lp, int src_pct,
		int sink_pct, logic with_hold);
		sdlp_pkg::time_t gen_now;
		logic gen_level;
		logic raw;
		int run_left;
		int cap;
		int roll;
		wait_drained();
		write_reg(sdlp_pkg::REG_DEBOUNCE_PERIOD, deb);
		write_reg(sdlp_pkg::REG_LONG_PRESS_PERIOD, lp);
		cfg_ch.valid <= 1'b0;
		src_idle_pct = src_pct;
		sink_idle_pct = sink_pct;
		cap = ((deb > lp) ? int'(deb) : int'(lp)) / 4 + 3;
		gen_now = $urandom;
		gen_level = 1'b1;
		run_left = 0;
		for (int i = 0; i < PhaseItems; i++) begin
			if (i == PhaseItems / 2)
				wait_drained();
			if (with_hold && i == 20)
				hold_left = 300;
			// Mostly steady presses and releases, with bounce, clears and time jumps
			if (run_left == 0) begin
				gen_level = ~gen_level;
				run_left = $urandom_range(1, 12);
			end else begin
				run_left--;
			end
			roll = $urandom_range(99);
			raw = (roll < 8) ? ~gen_level : gen_level;
			if (roll >= 97)
				gen_now = $urandom;
			else
				gen_now = gen_now + sdlp_pkg::time_t'($urandom_range(0, cap));
			send_poll(raw, gen_now, $urandom_range(99) < 10);
		end
	endtask

	// Receiver: random stalls, plus a long hold-off on request
	initial begin
		status_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				status_ch.ready <= 1'b0;
				hold_left--;
			end else begin
				status_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
			end
		end
	end

	task automatic check_bit(string name, logic want, logic got);
		if (got !== want) begin
			$error("%s: expected %0b, got %0b", name, want, got);
			fail_cnt++;
		end
	endtask

	always @(posedge clk) begin : status_check
		sdlp_pkg::result_t want;
		if (arst_n && status_ch.valid && status_ch.ready) begin
			if (status_q.size() == 0) begin
				$error("status transaction with no poll pending");
				fail_cnt++;
			end else begin
				want = status_q.pop_front();
				check_bit("switched", want.switched, status_ch.switched);
				check_bit("is_on", want.is_on, status_ch.is_on);
				check_bit("pushed", want.pushed, status_ch.pushed);
				check_bit("released", want.released, status_ch.released);
				check_bit("long_press", want.long_press, status_ch.long_press);
			end
		end
	end

	initial begin
		cycle_cnt = 0;
		while (cycle_cnt < CycleLimit) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("FAILURE");
		$finish;
	end

	initial begin
		logic writing;
		script_row_t row;
		fail_cnt = 0;
		hold_left = 0;
		src_idle_pct = 32;
		sink_idle_pct = 60;
		last_raw = 1'b1;
		deb_level = 1'b1;
		change_at = '0;
		press_at = '0;
		hold_seen = 1'b0;
		switched_sticky = 1'b0;
		long_sticky = 1'b0;
		debounce_ms = sdlp_pkg::DebounceReset;
		long_press_ms = sdlp_pkg::LongPressReset;
		writing = 1'b0;
		arst_n <= 1'b0;
		poll_ch.valid <= 1'b0;
		poll_ch.raw_level <= 1'b1;
		poll_ch.now_ms <= '0;
		poll_ch.clear_events <= 1'b0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.index <= sdlp_pkg::REG_DEBOUNCE_PERIOD;
		cfg_ch.data <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (Script[i]) begin
			row = Script[i];
			if (row.kind == ROW_WRITE) begin
				if (!writing)
					wait_drained();
				write_reg(row.idx, row.data);
				writing = 1'b1;
			end else begin
				if (writing)
					cfg_ch.valid <= 1'b0;
				writing = 1'b0;
				send_poll(row.raw, row.now, row.clr, row.typed, row.status);
			end
		end

		run_phase(sdlp_pkg::period_t'($urandom_range(0, 100)),
			sdlp_pkg::period_t'($urandom_range(0, 2000)), 32, 60, 1'b0);
		run_phase('0, '0, 60, 32, 1'b0);
		run_phase('1, '1, 0, 0, 1'b0);
		run_phase(sdlp_pkg::period_t'($urandom_range(1, 30)),
			sdlp_pkg::period_t'($urandom_range(30, 300)), 0, 0, 1'b1);

		wait_drained();
		repeat (4) @(posedge clk);
		if (fail_cnt == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
